>>> rtl/core/wpo_pkg.sv
// wavetable phase oscillator: shared types and constants
// no dependencies; imported by wpo_inc_store and wavetable_phase_oscillator
`default_nettype none

package wpo_pkg;

   // request kinds, carried on req_tuser
   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_WAVE_WR  = 2'd1,
      CMD_INC_WR   = 2'd2
   } cmd_type;

   localparam int CMD_W      = 2;
   localparam int PITCH_W    = 10;
   localparam int TSEL_W     = 4;
   localparam int IDX_W      = 7;
   localparam int SAMPLE_W   = 8;
   localparam int INC_W      = 29;
   localparam int OUT_W      = 12;
   localparam int FRAC_BITS  = 22;
   localparam int PITCH_SPAN = 60;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 16;

   // increment write request from the request stage to the increment store
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  slot;
      logic [INC_W-1:0]  value;
   } inc_wr_type;

endpackage : wpo_pkg

`default_nettype wire

>>> rtl/core/wpo_inc_store.sv
// increment store: pitch to note slot mapping, increment memory, write-side reduction
// depends on wpo_pkg
`default_nettype none

module wpo_inc_store #(
   parameter int TABLE_SAMPLES = 128,
   parameter int NOTE_SLOTS    = 60
) (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic [wpo_pkg::PITCH_W-1:0]          pitch,
   input  wpo_pkg::inc_wr_type                  wr,
   output logic [wpo_pkg::INC_W-1:0]            rd_data
);
   import wpo_pkg::*;

   localparam int SLOT_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
   localparam int PROD_W = PITCH_W + 6;
   localparam int INT_W  = INC_W - FRAC_BITS;
   localparam logic [7:0]  SLOTS_8    = 8'(NOTE_SLOTS);
   localparam logic [7:0]  LAST_SLOT  = 8'(NOTE_SLOTS - 1);
   localparam logic [10:0] SAMPLES_11 = 11'(TABLE_SAMPLES);

   logic [INC_W-1:0]  inc_mem [NOTE_SLOTS];
   logic [INC_W-1:0]  rd_data_ff;

   logic [PROD_W-1:0] prod;
   logic [7:0]        slot_raw;
   logic [7:0]        slot;
   logic [10:0]       rem;
   logic [INC_W-1:0]  red_value;
   logic              wr_ok;

   // slot = (pitch * 60) >> 10, clamped to the last slot
   always_comb begin
      prod     = PROD_W'(pitch) * PROD_W'(PITCH_SPAN);
      slot_raw = 8'(prod[PROD_W-1:PITCH_W]);
      slot     = (slot_raw >= SLOTS_8) ? LAST_SLOT : slot_raw;
   end

   // keep increments below one table length so one wrap subtraction suffices
   always_comb begin
      rem = 11'(wr.value[INC_W-1:FRAC_BITS]);
      for (int k = 0; k < 8; k++) begin
         if (rem >= SAMPLES_11) begin
            rem = rem - SAMPLES_11;
         end
      end
      red_value = {rem[INT_W-1:0], wr.value[FRAC_BITS-1:0]};
      wr_ok     = wr.en && ({1'b0, wr.slot} < SLOTS_8);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= inc_mem[slot[SLOT_W-1:0]];
      end
      if (wr_ok) begin
         inc_mem[wr.slot[SLOT_W-1:0]] <= red_value;
      end
   end

   assign rd_data = rd_data_ff;

endmodule : wpo_inc_store

`default_nettype wire

>>> rtl/core/wavetable_phase_oscillator.sv
// wavetable phase oscillator top level: request stage, phase accumulator, wave memory
// depends on wpo_pkg and wpo_inc_store
//
//  channel  direction  tdata                                  tuser
//  req_     in         pitch, table_sel, entry_index,         cmd
//                      sample_value, increment_value
//  rsp_     out        sample_out                             -
//
// one transfer per cycle sustained on req_ for any mix of ticks and writes while rsp_ is not stalled
// a tick's sample reaches rsp_ through registered steps in order: increment read, then
// phase add/wrap with the wave read; the phase loop closes within the add/wrap step
// reset clears the phase and the stage valids; both stores are unset until written
// a stalled rsp_ holds its sample; writes keep draining and req_ stays open until
// a tick reaches the stage in front of the held output
`default_nettype none

module wavetable_phase_oscillator #(
   parameter int TABLE_SAMPLES = 128,
   parameter int TABLE_COUNT   = 8,
   parameter int NOTE_SLOTS    = 60
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pitch[9:0], table_sel[13:10], entry_index[20:14], sample_value[28:21],
   // increment_value[57:29], zero[63:58]
   input  logic [wpo_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd[1:0]
   input  logic [wpo_pkg::CMD_W-1:0]          req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // sample_out[11:0], zero[15:12]
   output logic [wpo_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import wpo_pkg::*;

   localparam int POS_W   = $clog2(TABLE_SAMPLES);
   localparam int PHASE_W = POS_W + FRAC_BITS;
   localparam int SUM_W   = ((PHASE_W > INC_W) ? PHASE_W : INC_W) + 1;
   localparam int ADDR_W  = $clog2(TABLE_SAMPLES * TABLE_COUNT);
   localparam logic [SUM_W-1:0]  LIMIT      = SUM_W'(TABLE_SAMPLES) << FRAC_BITS;
   localparam logic [4:0]        COUNT_5    = 5'(TABLE_COUNT);
   localparam logic [TSEL_W-1:0] LAST_TABLE = TSEL_W'(TABLE_COUNT - 1);
   localparam logic [10:0]       SAMPLES_11 = 11'(TABLE_SAMPLES);

   // request fields
   logic [PITCH_W-1:0]         req_pitch;
   logic [TSEL_W-1:0]          req_tsel;
   logic [IDX_W-1:0]           req_idx;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic [INC_W-1:0]           req_inc;
   cmd_type                    req_cmd;

   logic                       accept;
   logic [TSEL_W-1:0]          tsel_clamped;
   logic [ADDR_W-1:0]          base_in;
   inc_wr_type                 inc_wr;
   logic [INC_W-1:0]           inc_rd;

   // stage 1
   logic                       s1_valid_ff, s1_valid_in;
   cmd_type                    s1_cmd_ff;
   logic [ADDR_W-1:0]          s1_base_ff;
   logic [IDX_W-1:0]           s1_idx_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic                       s1_tick;
   logic                       s1_retire;
   logic                       out_free;

   // phase accumulator
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic [SUM_W-1:0]           sum;
   logic [SUM_W-1:0]           wrapped;
   logic [POS_W-1:0]           pos;

   // wave memory
   logic [SAMPLE_W-1:0]        wave_mem [TABLE_SAMPLES * TABLE_COUNT];
   logic [SAMPLE_W-1:0]        wave_rd_ff;
   logic [ADDR_W-1:0]          wave_rd_addr;
   logic [ADDR_W-1:0]          wave_wr_addr;
   logic                       wave_we;

   logic                       rsp_valid_ff, rsp_valid_in;

   assign req_pitch  = req_tdata[9:0];
   assign req_tsel   = req_tdata[13:10];
   assign req_idx    = req_tdata[20:14];
   assign req_sample = req_tdata[28:21];
   assign req_inc    = req_tdata[57:29];
   assign req_cmd    = cmd_type'(req_tuser);

   // handshake and stage control
   always_comb begin
      out_free    = !rsp_valid_ff || rsp_tready;
      s1_tick     = s1_valid_ff && (s1_cmd_ff == CMD_TICK);
      s1_retire   = s1_valid_ff && (!s1_tick || out_free);
      req_tready  = !s1_valid_ff || s1_retire;
      accept      = req_tvalid && req_tready;
      s1_valid_in = accept ? 1'b1 : (s1_retire ? 1'b0 : s1_valid_ff);
      rsp_valid_in = out_free ? s1_tick : rsp_valid_ff;
   end

   // table base address, clamped table
   always_comb begin
      tsel_clamped = ({1'b0, req_tsel} >= COUNT_5) ? LAST_TABLE : req_tsel;
      base_in      = ADDR_W'(tsel_clamped) * ADDR_W'(TABLE_SAMPLES);
   end

   always_comb begin
      inc_wr.en    = accept && (req_cmd == CMD_INC_WR);
      inc_wr.slot  = req_idx;
      inc_wr.value = req_inc;
   end

   wpo_inc_store #(
      .TABLE_SAMPLES (TABLE_SAMPLES),
      .NOTE_SLOTS    (NOTE_SLOTS)
   ) u_inc_store (
      .clock   (clock),
      .rd_en   (accept),
      .pitch   (req_pitch),
      .wr      (inc_wr),
      .rd_data (inc_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff    <= req_cmd;
         s1_base_ff   <= base_in;
         s1_idx_ff    <= req_idx;
         s1_sample_ff <= req_sample;
      end
   end

   // phase add and wrap; the stored increment is already below one table
   always_comb begin
      sum      = SUM_W'(phase_ff) + SUM_W'(inc_rd);
      wrapped  = (sum >= LIMIT) ? (sum - LIMIT) : sum;
      phase_in = wrapped[PHASE_W-1:0];
      pos      = wrapped[FRAC_BITS +: POS_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (s1_tick && out_free) begin
         phase_ff <= phase_in;
      end
   end

   // writes land in the same stage as tick reads, so request order is kept
   always_comb begin
      wave_rd_addr = s1_base_ff + ADDR_W'(pos);
      wave_wr_addr = s1_base_ff + ADDR_W'(s1_idx_ff);
      wave_we      = s1_valid_ff && (s1_cmd_ff == CMD_WAVE_WR)
                     && (11'(s1_idx_ff) < SAMPLES_11);
   end

   always_ff @(posedge clock) begin
      if (s1_tick && out_free) begin
         wave_rd_ff <= wave_mem[wave_rd_addr];
      end
      if (wave_we) begin
         wave_mem[wave_wr_addr] <= s1_sample_ff;
      end
   end

   // sample + 128 is the sign bit flipped
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - OUT_W)'(0), ~wave_rd_ff[SAMPLE_W-1],
                        wave_rd_ff[SAMPLE_W-2:0], 4'b0000};

`ifndef NO_ASSERTIONS
   a_phase_moves_on_tick_only: assert property (@(posedge clock) disable iff (reset)
      !(s1_tick && out_free) |=> $stable(phase_ff))
      else $error("phase changed without a tick leaving stage 1");

   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s1_tick && out_free))
      else $error("result raised without a tick");

   a_stalled_tick_holds_inc: assert property (@(posedge clock) disable iff (reset)
      (s1_tick && !out_free) |=> $stable(inc_rd))
      else $error("increment read data lost under stall");

   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      s1_tick |-> (SUM_W'(phase_ff) < LIMIT))
      else $error("phase at or past table length");
`endif

endmodule : wavetable_phase_oscillator

`default_nettype wire
